// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the Bloom filter block.
// Needs nothing else; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BFIQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bloom filter check failed");

// antecedent implies consequent in the next cycle
`define BFIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bloom filter check failed");

`endif

// ===== hdl/bfiq_pkg.sv =====
// Package of the Bloom filter block: sizes, constants, codes and the
// command/status types between controller and datapath. No dependencies.
package bfiq_pkg;

  localparam int MAX_FILTER_BITS = 1024;
  localparam int MAX_HASHES      = 4;
  localparam int ADDR_W          = $clog2(MAX_FILTER_BITS);
  localparam int SIZE_W          = ADDR_W + 1;
  localparam int LANE_W          = $clog2(MAX_HASHES);
  localparam int CNT_W           = LANE_W + 1;
  localparam int WORD_W          = 32;
  localparam int BYTE_W          = 8;
  localparam int HC_W            = 3;
  localparam int FS_W            = 11;
  localparam int CFG_IDX_W       = 3;
  localparam int MOD_STEPS       = 4;
  localparam int MOD_CYCLES      = WORD_W / MOD_STEPS;
  localparam int MOD_CNT_W       = $clog2(MOD_CYCLES);

  localparam logic [WORD_W-1:0] MULT_START = 32'd63689;
  localparam logic [WORD_W-1:0] HASH_MASK  = 32'h7FFF_FFFF;
  localparam logic [HC_W-1:0]   HC_RESET   = 3'd3;
  localparam logic [FS_W-1:0]   FS_RESET   = 11'd1024;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_COUNT  = 3'd0,
    CFG_FILTER_SIZE = 3'd1,
    CFG_SEED_ZERO   = 3'd2,
    CFG_SEED_ONE    = 3'd3,
    CFG_SEED_TWO    = 3'd4,
    CFG_SEED_THREE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_HASH   = 8'b0000_0100,
    S_MSTART = 8'b0000_1000,
    S_MOD    = 8'b0001_0000,
    S_MEM    = 8'b0010_0000,
    S_CHECK  = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic              load;
    logic              lane_upd;
    logic [LANE_W-1:0] lane;
    logic              restart;
    logic              mod_start;
    logic [LANE_W-1:0] hidx;
    logic              mem_go;
    logic              check;
    logic              emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             clear_done;
    logic             mod_done;
    logic             key_last;
    logic             query;
    logic [CNT_W-1:0] count_eff;
    logic             out_busy;
  } dp_stat_t;

endpackage

// ===== hdl/bloom_filter_insert_query_top.sv =====
// Bloom filter over byte-string keys, one key byte per request; up to four
// seeded multiplicative hashes. After reset the 1024-bit store is swept to
// zero, during which no request is taken (config writes are). Each byte
// runs four hash lanes that share one pair of 32-bit multipliers, one lane
// per cycle. A last byte then runs, per hash in use, a remainder unit doing
// four bit steps per cycle, then one bit store access and check; a query
// then posts its result once the result register is free. The result
// register lets a waiting result sit while the next key streams in.
// Depends on bfiq_pkg, bfiq_ctrl, bfiq_dp, assert_macros.svh.
`include "assert_macros.svh"

module bloom_filter_insert_query_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfiq_pkg::WORD_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [bfiq_pkg::BYTE_W-1:0]    in_key_byte,
  input  logic                           in_key_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_member
);

  bfiq_pkg::ctrl_cmd_t cmd;
  bfiq_pkg::dp_stat_t  stat;
  logic                cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  bfiq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfiq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mode       (in_mode),
    .in_key_byte   (in_key_byte),
    .in_key_last   (in_key_last),
    .cmd           (cmd),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_is_member (out_is_member)
  );

  `BFIQ_ASSERT_IMP(a_accept_after_clear, clk, rst_n, in_valid && !in_stall, stat.clear_done)
  `BFIQ_ASSERT_IMP(a_mem_after_mod, clk, rst_n, cmd.mem_go, $past(stat.mod_done))
  `BFIQ_ASSERT_IMP(a_emit_when_free, clk, rst_n, cmd.emit, !stat.out_busy)
  `BFIQ_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid)

endmodule

// ===== hdl/bfiq_mod.sv =====
// Iterative remainder unit, four restoring steps per cycle.
// Depends on bfiq_pkg.
module bfiq_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bfiq_pkg::WORD_W-1:0]  dividend,
  input  logic [bfiq_pkg::SIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [bfiq_pkg::SIZE_W-1:0]  rem
);

  logic                           busy_r;
  logic                           done_r;
  logic [bfiq_pkg::MOD_CNT_W-1:0] cnt_r;
  logic [bfiq_pkg::WORD_W-1:0]    num_r;
  logic [bfiq_pkg::SIZE_W-1:0]    rem_r;
  logic [bfiq_pkg::SIZE_W-1:0]    div_r;
  logic [bfiq_pkg::WORD_W-1:0]    num_nxt;
  logic [bfiq_pkg::SIZE_W-1:0]    rem_nxt;

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    for (int j = 0; j < bfiq_pkg::MOD_STEPS; j++) begin
      rem_nxt = {rem_nxt[bfiq_pkg::SIZE_W-2:0], num_nxt[bfiq_pkg::WORD_W-1]};
      num_nxt = {num_nxt[bfiq_pkg::WORD_W-2:0], 1'b0};
      if (rem_nxt >= div_r) begin
        rem_nxt = rem_nxt - div_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + bfiq_pkg::MOD_CNT_W'(1);
        if (cnt_r == bfiq_pkg::MOD_CNT_W'(bfiq_pkg::MOD_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/bfiq_dp.sv =====
// Datapath: config registers, hash lanes, remainder unit, bit store
// with clearing sweep, result register. Depends on bfiq_pkg, bfiq_mod.
module bfiq_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfiq_pkg::WORD_W-1:0]    cfg_data,
  input  logic                           in_mode,
  input  logic [bfiq_pkg::BYTE_W-1:0]    in_key_byte,
  input  logic                           in_key_last,
  input  bfiq_pkg::ctrl_cmd_t            cmd,
  output bfiq_pkg::dp_stat_t             stat,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           out_is_member
);

  logic [bfiq_pkg::HC_W-1:0]   hash_count_r;
  logic [bfiq_pkg::FS_W-1:0]   filter_size_r;
  logic [bfiq_pkg::WORD_W-1:0] seed_r [bfiq_pkg::MAX_HASHES];

  logic [bfiq_pkg::BYTE_W-1:0] byte_r;
  logic                        last_r;
  logic                        mode_r;
  logic                        member_r;
  logic [bfiq_pkg::WORD_W-1:0] hash_r [bfiq_pkg::MAX_HASHES];
  logic [bfiq_pkg::WORD_W-1:0] mult_r [bfiq_pkg::MAX_HASHES];
  logic [bfiq_pkg::WORD_W-1:0] hash_nxt;
  logic [bfiq_pkg::WORD_W-1:0] mult_nxt;
  logic [bfiq_pkg::WORD_W-1:0] prod;

  logic [bfiq_pkg::CNT_W-1:0]  count_eff;
  logic [bfiq_pkg::SIZE_W-1:0] size_eff;
  logic                        mod_done;
  logic [bfiq_pkg::SIZE_W-1:0] pos;

  logic                        mem [bfiq_pkg::MAX_FILTER_BITS];
  logic [bfiq_pkg::ADDR_W-1:0] clr_addr_r;
  logic                        clear_done_r;
  logic                        rd_bit_r;
  logic                        mem_we;
  logic                        mem_wd;
  logic [bfiq_pkg::ADDR_W-1:0] mem_addr;

  logic                        out_valid_r;
  logic                        out_is_member_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_count_r  <= bfiq_pkg::HC_RESET;
      filter_size_r <= bfiq_pkg::FS_RESET;
      for (int i = 0; i < bfiq_pkg::MAX_HASHES; i++) begin
        seed_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (bfiq_pkg::cfg_idx_t'(cfg_index))
        bfiq_pkg::CFG_HASH_COUNT:  hash_count_r  <= cfg_data[bfiq_pkg::HC_W-1:0];
        bfiq_pkg::CFG_FILTER_SIZE: filter_size_r <= cfg_data[bfiq_pkg::FS_W-1:0];
        bfiq_pkg::CFG_SEED_ZERO:   seed_r[0]     <= cfg_data;
        bfiq_pkg::CFG_SEED_ONE:    seed_r[1]     <= cfg_data;
        bfiq_pkg::CFG_SEED_TWO:    seed_r[2]     <= cfg_data;
        bfiq_pkg::CFG_SEED_THREE:  seed_r[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (hash_count_r > bfiq_pkg::HC_W'(bfiq_pkg::MAX_HASHES)) begin
      count_eff = bfiq_pkg::CNT_W'(bfiq_pkg::MAX_HASHES);
    end else begin
      count_eff = bfiq_pkg::CNT_W'(hash_count_r);
    end
    if (filter_size_r == '0) begin
      size_eff = bfiq_pkg::SIZE_W'(1);
    end else if (filter_size_r > bfiq_pkg::FS_W'(bfiq_pkg::MAX_FILTER_BITS)) begin
      size_eff = bfiq_pkg::SIZE_W'(bfiq_pkg::MAX_FILTER_BITS);
    end else begin
      size_eff = bfiq_pkg::SIZE_W'(filter_size_r);
    end
  end

  // request capture and query flag
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r   <= in_key_byte;
      last_r   <= in_key_last;
      mode_r   <= in_mode;
      member_r <= 1'b1;
    end else if (cmd.check && mode_r == bfiq_pkg::MODE_QUERY) begin
      member_r <= member_r & rd_bit_r;
    end
  end

  // one hash lane per cycle
  assign prod     = hash_r[cmd.lane] * mult_r[cmd.lane];
  assign hash_nxt = prod + bfiq_pkg::WORD_W'(byte_r);
  assign mult_nxt = mult_r[cmd.lane] * seed_r[cmd.lane];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < bfiq_pkg::MAX_HASHES; i++) begin
        hash_r[i] <= '0;
        mult_r[i] <= bfiq_pkg::MULT_START;
      end
    end else if (cmd.lane_upd) begin
      hash_r[cmd.lane] <= hash_nxt;
      mult_r[cmd.lane] <= mult_nxt;
    end
  end

  bfiq_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (hash_r[cmd.hidx] & bfiq_pkg::HASH_MASK),
    .divisor  (size_eff),
    .done     (mod_done),
    .rem      (pos)
  );

  // bit store, swept to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      clear_done_r <= 1'b0;
    end else if (!clear_done_r) begin
      clr_addr_r <= clr_addr_r + bfiq_pkg::ADDR_W'(1);
      if (clr_addr_r == '1) begin
        clear_done_r <= 1'b1;
      end
    end
  end

  assign mem_we   = !clear_done_r || (cmd.mem_go && mode_r == bfiq_pkg::MODE_INSERT);
  assign mem_wd   = clear_done_r;
  assign mem_addr = clear_done_r ? pos[bfiq_pkg::ADDR_W-1:0] : clr_addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_bit_r <= mem[mem_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_is_member_r <= member_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_member = out_is_member_r;

  assign stat.clear_done = clear_done_r;
  assign stat.mod_done   = mod_done;
  assign stat.key_last   = last_r;
  assign stat.query      = (mode_r == bfiq_pkg::MODE_QUERY);
  assign stat.count_eff  = count_eff;
  assign stat.out_busy   = out_valid_r && out_stall;

endmodule

// ===== hdl/bfiq_ctrl.sv =====
// Controller state machine: sequences lane updates, remainders, bit
// store accesses and result delivery. Depends on bfiq_pkg.
module bfiq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bfiq_pkg::dp_stat_t  stat,
  output bfiq_pkg::ctrl_cmd_t cmd
);

  bfiq_pkg::state_t                state_r, state_nxt;
  logic [bfiq_pkg::LANE_W-1:0]     lane_r, lane_nxt;
  logic [bfiq_pkg::LANE_W-1:0]     hidx_r, hidx_nxt;
  logic                            last_hash;

  assign last_hash = (bfiq_pkg::CNT_W'(hidx_r) + bfiq_pkg::CNT_W'(1)) == stat.count_eff;

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    hidx_nxt  = hidx_r;
    cmd       = '0;
    cmd.lane  = lane_r;
    cmd.hidx  = hidx_r;
    case (state_r)
      bfiq_pkg::S_CLEAR: begin
        if (stat.clear_done) begin
          state_nxt = bfiq_pkg::S_IDLE;
        end
      end
      bfiq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          lane_nxt  = '0;
          state_nxt = bfiq_pkg::S_HASH;
        end
      end
      bfiq_pkg::S_HASH: begin
        cmd.lane_upd = 1'b1;
        lane_nxt     = lane_r + bfiq_pkg::LANE_W'(1);
        if (lane_r == bfiq_pkg::LANE_W'(bfiq_pkg::MAX_HASHES - 1)) begin
          lane_nxt = '0;
          if (!stat.key_last) begin
            state_nxt = bfiq_pkg::S_IDLE;
          end else if (stat.count_eff == '0) begin
            cmd.restart = 1'b1;
            state_nxt   = stat.query ? bfiq_pkg::S_EMIT : bfiq_pkg::S_IDLE;
          end else begin
            hidx_nxt  = '0;
            state_nxt = bfiq_pkg::S_MSTART;
          end
        end
      end
      bfiq_pkg::S_MSTART: begin
        cmd.mod_start = 1'b1;
        state_nxt     = bfiq_pkg::S_MOD;
      end
      bfiq_pkg::S_MOD: begin
        if (stat.mod_done) begin
          state_nxt = bfiq_pkg::S_MEM;
        end
      end
      bfiq_pkg::S_MEM: begin
        cmd.mem_go = 1'b1;
        state_nxt  = bfiq_pkg::S_CHECK;
      end
      bfiq_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        if (last_hash) begin
          cmd.restart = 1'b1;
          state_nxt   = stat.query ? bfiq_pkg::S_EMIT : bfiq_pkg::S_IDLE;
        end else begin
          hidx_nxt  = hidx_r + bfiq_pkg::LANE_W'(1);
          state_nxt = bfiq_pkg::S_MSTART;
        end
      end
      bfiq_pkg::S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = bfiq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfiq_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfiq_pkg::S_CLEAR;
      lane_r  <= '0;
      hidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
      hidx_r  <= hidx_nxt;
    end
  end

  assign in_stall = (state_r != bfiq_pkg::S_IDLE);

endmodule

// ===== tb/bloom_filter_insert_query_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench of bloom_filter_insert_query_top: keys stream in byte by byte while a
// behavioral filter in the bench predicts every query answer. Needs bfiq_pkg and RTL.
module bloom_filter_insert_query_top_tb;

  localparam int SETTLE_CYCLES = 100;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int KEY_MAX       = 8;
  localparam int PHASES        = 8;

  typedef struct packed {
    logic [3:0]           len;
    logic [KEY_MAX*8-1:0] bytes;
  } key_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [bfiq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bfiq_pkg::WORD_W-1:0]    cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_mode;
  logic [bfiq_pkg::BYTE_W-1:0]    in_key_byte;
  logic                           in_key_last;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_is_member;

  bit calm;
  int failures;
  int items_sent;

  logic [bfiq_pkg::HC_W-1:0]   num_hashes;
  logic [bfiq_pkg::FS_W-1:0]   filter_bits;
  logic [bfiq_pkg::WORD_W-1:0] seed_word[bfiq_pkg::MAX_HASHES];
  logic [bfiq_pkg::WORD_W-1:0] lane_hash[bfiq_pkg::MAX_HASHES];
  logic [bfiq_pkg::WORD_W-1:0] lane_mult[bfiq_pkg::MAX_HASHES];
  bit                          filter_store[bfiq_pkg::MAX_FILTER_BITS];
  bit                          expected_answers[$];
  key_t                        inserted_keys[$];

  bloom_filter_insert_query_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_key_byte(in_key_byte), .in_key_last(in_key_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_is_member(out_is_member)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("[bloom_filter_insert_query_top] ERROR");
    $finish;
  end

  function automatic void restart_lanes();
    for (int i = 0; i < bfiq_pkg::MAX_HASHES; i++) begin
      lane_hash[i] = '0;
      lane_mult[i] = bfiq_pkg::MULT_START;
    end
  endfunction

  function automatic void absorb_byte(logic mode, logic [7:0] b, logic last);
    int unsigned                 used;
    logic [bfiq_pkg::WORD_W-1:0] modulus;
    logic [bfiq_pkg::WORD_W-1:0] pos;
    bit                          hit;
    hit = 1'b1;
    for (int i = 0; i < bfiq_pkg::MAX_HASHES; i++) begin
      lane_hash[i] = lane_hash[i] * lane_mult[i] + {24'd0, b};
      lane_mult[i] = lane_mult[i] * seed_word[i];
    end
    if (last) begin
      used = (num_hashes > bfiq_pkg::MAX_HASHES) ? bfiq_pkg::MAX_HASHES : int'(num_hashes);
      if (filter_bits == '0)
        modulus = 32'd1;
      else if (filter_bits > bfiq_pkg::MAX_FILTER_BITS)
        modulus = bfiq_pkg::MAX_FILTER_BITS;
      else
        modulus = {21'd0, filter_bits};
      for (int i = 0; i < used; i++) begin
        pos = (lane_hash[i] & bfiq_pkg::HASH_MASK) % modulus;
        if (mode == bfiq_pkg::MODE_INSERT)
          filter_store[pos] = 1'b1;
        else if (!filter_store[pos])
          hit = 1'b0;
      end
      restart_lanes();
      if (mode == bfiq_pkg::MODE_QUERY)
        expected_answers.insert(expected_answers.size(), hit);
    end
  endfunction

  function automatic key_t key_of(int len, logic [KEY_MAX*8-1:0] bytes);
    key_t k;
    k.len   = len[3:0];
    k.bytes = bytes;
    return k;
  endfunction

  // mostly short keys; a zero byte now and then
  function automatic key_t make_key();
    key_t k;
    k.len   = ($urandom_range(9) < 8) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(5, KEY_MAX));
    k.bytes = '0;
    for (int i = 0; i < KEY_MAX; i++)
      k.bytes[8*i +: 8] = ($urandom_range(11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    return k;
  endfunction

  task automatic send_byte(input logic mode, input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_key_byte <= b;
    in_key_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(mode, b, last);
    items_sent++;
  endtask

  task automatic send_key(input key_t k, input logic mode);
    logic last;
    for (int i = 0; i < k.len; i++) begin
      last = (i == k.len - 1);
      send_byte(last ? mode : logic'($urandom_range(1)), k.bytes[8*i +: 8], last);
    end
  endtask

  task automatic write_reg(input bfiq_pkg::cfg_idx_t idx,
                           input logic [bfiq_pkg::WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bfiq_pkg::CFG_HASH_COUNT:  num_hashes   = value[bfiq_pkg::HC_W-1:0];
      bfiq_pkg::CFG_FILTER_SIZE: filter_bits  = value[bfiq_pkg::FS_W-1:0];
      bfiq_pkg::CFG_SEED_ZERO:   seed_word[0] = value;
      bfiq_pkg::CFG_SEED_ONE:    seed_word[1] = value;
      bfiq_pkg::CFG_SEED_TWO:    seed_word[2] = value;
      bfiq_pkg::CFG_SEED_THREE:  seed_word[3] = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // no results come from inserts, so give the last one time to land
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_answers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_setting();
    send_key(key_of(1, 64'h41), bfiq_pkg::MODE_INSERT);
    send_key(key_of(1, 64'h41), bfiq_pkg::MODE_QUERY);
    send_key(key_of(3, 64'h01_80_FF), bfiq_pkg::MODE_INSERT);
    send_key(key_of(3, 64'h01_80_FF), bfiq_pkg::MODE_QUERY);
    send_key(key_of(2, 64'h7F_00), bfiq_pkg::MODE_QUERY);
    settle();
  endtask

  task automatic test_setting_extremes();
    write_reg(bfiq_pkg::CFG_HASH_COUNT, 32'd0);
    send_key(key_of(1, 64'h5A), bfiq_pkg::MODE_QUERY);
    settle();
    write_reg(bfiq_pkg::CFG_HASH_COUNT, 32'd7);
    write_reg(bfiq_pkg::CFG_FILTER_SIZE, 32'd2047);
    write_reg(bfiq_pkg::CFG_SEED_ZERO, 32'hFFFF_FFFF);
    write_reg(bfiq_pkg::CFG_SEED_ONE, 32'hFFFF_FFFF);
    write_reg(bfiq_pkg::CFG_SEED_TWO, 32'hFFFF_FFFF);
    write_reg(bfiq_pkg::CFG_SEED_THREE, 32'hFFFF_FFFF);
    send_key(key_of(1, 64'h51), bfiq_pkg::MODE_INSERT);
    send_key(key_of(1, 64'h51), bfiq_pkg::MODE_QUERY);
    settle();
    write_reg(bfiq_pkg::CFG_HASH_COUNT, 32'd4);
    write_reg(bfiq_pkg::CFG_FILTER_SIZE, 32'd0);
    send_key(key_of(1, 64'h78), bfiq_pkg::MODE_QUERY);
    send_key(key_of(1, 64'h78), bfiq_pkg::MODE_INSERT);
    send_key(key_of(1, 64'h78), bfiq_pkg::MODE_QUERY);
    settle();
  endtask

  task automatic test_random_phases();
    int unsigned                 counts[PHASES] = '{4, 1, 7, 2, 3, 5, 0, 6};
    int unsigned                 sizes[PHASES]  = '{1024, 1, 2047, 13, 0, 1000, 1025, 0};
    logic [bfiq_pkg::WORD_W-1:0] s;
    int                          goal;
    key_t                        k;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(bfiq_pkg::CFG_HASH_COUNT, counts[p]);
      write_reg(bfiq_pkg::CFG_FILTER_SIZE,
                (p == PHASES - 1) ? $urandom_range(1, 2047) : sizes[p]);
      for (int i = 0; i < bfiq_pkg::MAX_HASHES; i++) begin
        s = (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'd0 : $urandom();
        write_reg(bfiq_pkg::cfg_idx_t'(bfiq_pkg::CFG_SEED_ZERO + i), s);
      end
      inserted_keys.delete();
      goal = items_sent + 70;
      while (items_sent < goal) begin
        if ($urandom_range(1) == 0) begin
          k = make_key();
          inserted_keys.insert(inserted_keys.size(), k);
          send_key(k, bfiq_pkg::MODE_INSERT);
        end else if (inserted_keys.size() != 0 && $urandom_range(9) < 6) begin
          send_key(inserted_keys[$urandom_range(inserted_keys.size() - 1)],
                   bfiq_pkg::MODE_QUERY);
        end else begin
          send_key(make_key(), bfiq_pkg::MODE_QUERY);
        end
      end
      settle();
    end
  endtask

  task automatic test_back_to_back();
    key_t k;
    int   goal;
    calm = 1'b1;
    goal = items_sent + 80;
    while (items_sent < goal) begin
      k = make_key();
      send_key(k, bfiq_pkg::MODE_INSERT);
      send_key(($urandom_range(1) == 0) ? k : make_key(), bfiq_pkg::MODE_QUERY);
    end
    calm = 1'b0;
    settle();
  endtask

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 11);

  always @(posedge clk) begin : check_answers
    bit want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("is_member: no request pending, expected none, actual %0d", out_is_member);
        failures++;
      end else begin
        want = expected_answers.pop_front();
        if (out_is_member !== want) begin
          $error("is_member: expected %0d, actual %0d", want, out_is_member);
          failures++;
        end
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= bfiq_pkg::CFG_HASH_COUNT;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    in_mode     <= bfiq_pkg::MODE_INSERT;
    in_key_byte <= '0;
    in_key_last <= 1'b0;
    num_hashes  = bfiq_pkg::HC_RESET;
    filter_bits = bfiq_pkg::FS_RESET;
    foreach (seed_word[i]) seed_word[i] = '0;
    foreach (filter_store[i]) filter_store[i] = 1'b0;
    restart_lanes();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_setting();
    test_setting_extremes();
    test_random_phases();
    test_back_to_back();

    if (expected_answers.size() != 0) begin
      $error("is_member: expected %0d more results, actual none", expected_answers.size());
      failures++;
    end
    if (failures == 0)
      $display("[bloom_filter_insert_query_top] OK");
    else
      $display("[bloom_filter_insert_query_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bfiq_pkg.sv
hdl/bfiq_mod.sv
hdl/bfiq_dp.sv
hdl/bfiq_ctrl.sv
hdl/bloom_filter_insert_query_top.sv
tb/bloom_filter_insert_query_top_tb.sv
